// ----- sv/sfidc_pkg.sv -----
`default_nettype none
package sfidc_pkg;

  localparam int unsigned MEAS_W   = 16;          // measurement width, Q8.8
  localparam int unsigned VIN_W    = MEAS_W - 1;  // unsigned input voltage
  localparam int unsigned GAIN_W   = 32;          // Q16.16 gains, Q0.32 step
  localparam int unsigned INTEG_W  = 64;          // Q32.32 integrator
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned IN_DATA_W = 80;         // 79 bits of fields, byte padded
  localparam int unsigned DIV_W    = 80;          // divider dividend/quotient width
  localparam int unsigned DIV_CNT_W = 7;

  // operation codes carried in tuser
  localparam logic [1:0] OP_RUN     = 2'd0;
  localparam logic [1:0] OP_PRELOAD = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_GAIN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_STEP     = 4'd3;

  localparam logic [31:0] RST_CURRENT_GAIN  = 32'd1321;
  localparam logic [31:0] RST_VOLTAGE_GAIN  = -32'sd5156;
  localparam logic [31:0] RST_INTEGRAL_GAIN = -32'sd303548;
  localparam logic [31:0] RST_HALF_STEP     = 32'd21475;

  // multiplier operand selects
  localparam logic [2:0] MUL_INC    = 3'd0;  // half_step * (err + prev)
  localparam logic [2:0] MUL_HI     = 3'd1;  // kev * integ[63:32]
  localparam logic [2:0] MUL_LO     = 3'd2;  // kev * integ[31:0]
  localparam logic [2:0] MUL_KI     = 3'd3;  // ki * i
  localparam logic [2:0] MUL_KV_V   = 3'd4;  // kv * v
  localparam logic [2:0] MUL_KV_VDC = 3'd5;  // kv * vdc

  // accumulator operations
  localparam logic [2:0] ACC_HOLD    = 3'd0;
  localparam logic [2:0] ACC_LOAD    = 3'd1;
  localparam logic [2:0] ACC_ITERM   = 3'd2;
  localparam logic [2:0] ACC_ADD     = 3'd3;
  localparam logic [2:0] ACC_NEG     = 3'd4;
  localparam logic [2:0] ACC_SUB     = 3'd5;
  localparam logic [2:0] ACC_RATIO   = 3'd6;

  typedef struct packed {
    logic       load;         // capture input beat
    logic       clear;        // clear integrator and previous error
    logic [2:0] mul_sel;
    logic [2:0] acc_op;
    logic       integ_upd;    // saturating integrator update, store error
    logic       div_start;
    logic       div_sel;      // 0: vdc/vin ratio, 1: preload quotient
    logic       preload_fin;  // write preload result to integrator
    logic       out_load;     // capture duty into output register
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } sts_t;

endpackage
`default_nettype wire

// ----- sv/state_feedback_integral_duty_controller.sv -----
// Run beat: steps from accept to duty in the output register (one shared
//   33x33 multiplier, five products in sequence); the next beat is accepted only once
//   the sequencer is back in idle. A stalled duty beat holds the sequencer.
// Preload beat: runs two passes of the 80-bit bit-serial divider.
// Reset-integrator beat: clears on accept. Unused operation code: dropped.
// Reset (rst_ni low, async): gains and half step back to defaults, integrator and
//   stored error cleared, no pending duty beat.
`default_nettype none
module state_feedback_integral_duty_controller (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input stream
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // tdata: inductor_current[15:0], output_voltage[31:16], reference_voltage[47:32],
  //        input_voltage[62:48], dc_output_voltage[78:63], zero pad[79]
  input  wire logic [sfidc_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // tuser: operation[1:0]
  input  wire logic [1:0]                          s_axis_tuser_i,
  // result stream
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // tdata: duty[15:0]
  output logic [sfidc_pkg::DUTY_W-1:0]             m_axis_tdata_o,
  // config write channel
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [sfidc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [31:0]                         cfg_data_i
);
  import sfidc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // config is always taken; writes land only while idle by contract
  assign cfg_ready_o = 1'b1;

  // sequencer: walks one beat through multiplier, accumulator and divider
  sfidc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_op_i     (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: gains, integrator, multiplier, accumulator, divider, duty register
  sfidc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .duty_o      (m_axis_tdata_o)
  );
endmodule
`default_nettype wire

// ----- sv/sfidc_div.sv -----
`default_nettype none
module sfidc_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [sfidc_pkg::DIV_W-1:0] dividend_i,
  input  wire logic [31:0]                 divisor_i,
  output logic                             busy_o,
  output logic [sfidc_pkg::DIV_W-1:0]      quotient_o
);
  import sfidc_pkg::*;

  // restoring divider, one quotient bit per cycle
  logic                  busy_q, busy_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [31:0]           rem_q, rem_d;
  logic [DIV_W-1:0]      quo_q, quo_d;
  logic [31:0]           dsr_q, dsr_d;
  logic [32:0]           trial;

  assign trial = {rem_q, quo_q[DIV_W-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = 32'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

// ----- sv/sfidc_dp.sv -----
`default_nettype none
module sfidc_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire sfidc_pkg::cmd_t                 cmd_i,
  output sfidc_pkg::sts_t                      sts_o,
  input  wire logic [sfidc_pkg::IN_DATA_W-1:0] in_data_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [sfidc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i,
  output logic [sfidc_pkg::DUTY_W-1:0]         duty_o
);
  import sfidc_pkg::*;

  logic signed [31:0] ki_q, kv_q, kev_q;
  logic        [31:0] hs_q;
  logic signed [MEAS_W-1:0] il_q, v_q, ref_q, vdc_q;
  logic        [VIN_W-1:0]  vin_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [MEAS_W:0]    prev_q;
  logic signed [65:0] prod_q;
  logic signed [63:0] acc_q, acc_d;
  logic [DUTY_W-1:0]  duty_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ki_q  <= RST_CURRENT_GAIN;
      kv_q  <= RST_VOLTAGE_GAIN;
      kev_q <= RST_INTEGRAL_GAIN;
      hs_q  <= RST_HALF_STEP;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CURRENT_GAIN:  ki_q  <= cfg_data_i;
        CFG_VOLTAGE_GAIN:  kv_q  <= cfg_data_i;
        CFG_INTEGRAL_GAIN: kev_q <= cfg_data_i;
        CFG_HALF_STEP:     hs_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input beat capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      il_q  <= in_data_i[15:0];
      v_q   <= in_data_i[31:16];
      ref_q <= in_data_i[47:32];
      vin_q <= in_data_i[62:48];
      vdc_q <= in_data_i[78:63];
    end
  end

  // error terms
  logic signed [MEAS_W:0]   err;
  logic signed [MEAS_W+1:0] esum;
  assign err  = {ref_q[MEAS_W-1], ref_q} - {v_q[MEAS_W-1], v_q};
  assign esum = {err[MEAS_W], err} + {prev_q[MEAS_W], prev_q};

  // shared multiplier, registered product
  logic signed [32:0] mul_a, mul_b;
  always_comb begin
    mul_a = {kev_q[31], kev_q};
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_INC: begin
        mul_a = {1'b0, hs_q};
        mul_b = {{(33-MEAS_W-2){esum[MEAS_W+1]}}, esum};
      end
      MUL_HI:  mul_b = {integ_q[63], integ_q[63:32]};
      MUL_LO:  mul_b = {1'b0, integ_q[31:0]};
      MUL_KI: begin
        mul_a = {ki_q[31], ki_q};
        mul_b = {{(33-MEAS_W){il_q[MEAS_W-1]}}, il_q};
      end
      MUL_KV_V: begin
        mul_a = {kv_q[31], kv_q};
        mul_b = {{(33-MEAS_W){v_q[MEAS_W-1]}}, v_q};
      end
      MUL_KV_VDC: begin
        mul_a = {kv_q[31], kv_q};
        mul_b = {{(33-MEAS_W){vdc_q[MEAS_W-1]}}, vdc_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) prod_q <= mul_a * mul_b;

  // divider operands
  logic [MEAS_W-1:0] vdc_mag;
  logic [63:0]       acc_mag;
  logic [31:0]       kev_mag;
  logic [DIV_W-1:0]  div_dividend;
  logic [31:0]       div_divisor;
  logic              div_busy;
  logic [DIV_W-1:0]  quo;

  assign vdc_mag = vdc_q[MEAS_W-1] ? MEAS_W'(-vdc_q) : vdc_q;
  assign acc_mag = acc_q[63] ? 64'(-acc_q) : acc_q;
  assign kev_mag = kev_q[31] ? 32'(-kev_q) : kev_q;

  always_comb begin
    if (cmd_i.div_sel) begin
      // |num| < 2^52, so 56 magnitude bits cover it
      div_dividend = {acc_mag[55:0], 24'd0};
      div_divisor  = kev_mag;
    end else begin
      div_dividend = {{(DIV_W-MEAS_W-24){1'b0}}, vdc_mag, 24'd0};
      div_divisor  = {{(32-VIN_W){1'b0}}, vin_q};
    end
  end

  sfidc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  assign sts_o.div_busy = div_busy;

  // accumulator
  logic signed [65:0] lo_sh;
  logic signed [63:0] ratio;
  assign lo_sh = prod_q >>> 24;
  assign ratio = (vin_q == '0) ? 64'sd0 :
                 vdc_q[MEAS_W-1] ? -$signed(quo[63:0]) : $signed(quo[63:0]);

  always_comb begin
    acc_d = acc_q;
    case (cmd_i.acc_op)
      ACC_LOAD:  acc_d = prod_q[63:0];
      ACC_ITERM: begin
        if (acc_q > (64'sd1 <<< 52))       acc_d = 64'sd1 <<< 60;
        else if (acc_q < -(64'sd1 <<< 52)) acc_d = -(64'sd1 <<< 60);
        else acc_d = (acc_q <<< 8) + lo_sh[63:0];
      end
      ACC_ADD:   acc_d = acc_q + prod_q[63:0];
      ACC_NEG:   acc_d = -prod_q[63:0];
      ACC_SUB:   acc_d = acc_q - prod_q[63:0];
      ACC_RATIO: acc_d = acc_q - ratio;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) acc_q <= acc_d;

  // integrator and stored error
  logic signed [65:0] inc;
  logic signed [64:0] isum;
  logic signed [63:0] pre_val;
  logic               pre_neg, pre_sat;
  assign inc  = prod_q >>> 8;
  assign isum = {integ_q[63], integ_q} + {inc[64], inc[63:0]};
  assign pre_neg = acc_q[63] ^ kev_q[31];
  assign pre_sat = |quo[DIV_W-1:63];

  always_comb begin
    if (kev_q == '0)  pre_val = '0;
    else if (pre_sat) pre_val = pre_neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else              pre_val = pre_neg ? -$signed(quo[63:0]) : $signed(quo[63:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (cmd_i.clear) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (cmd_i.integ_upd) begin
      if (isum[64] != isum[63]) integ_q <= isum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else                      integ_q <= isum[63:0];
      prev_q <= err;
    end else if (cmd_i.preload_fin) begin
      integ_q <= pre_val;
      prev_q  <= '0;
    end
  end

  // duty: -acc in Q.24, floor to Q0.16, clamp
  logic signed [63:0] u, d;
  assign u = -acc_q;
  assign d = u >>> 8;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (d < 0)                duty_q <= '0;
      else if (d > 64'sd65535)  duty_q <= '1;
      else                      duty_q <= d[DUTY_W-1:0];
    end
  end

  assign duty_o = duty_q;
endmodule
`default_nettype wire

// ----- sv/sfidc_ctrl.sv -----
`default_nettype none
module sfidc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [1:0]      in_op_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output sfidc_pkg::cmd_t      cmd_o,
  input  wire sfidc_pkg::sts_t sts_i
);
  import sfidc_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_R_INC = 4'd1;
  localparam logic [3:0] ST_R_INT = 4'd2;
  localparam logic [3:0] ST_R_HI  = 4'd3;
  localparam logic [3:0] ST_R_LO  = 4'd4;
  localparam logic [3:0] ST_R_KI  = 4'd5;
  localparam logic [3:0] ST_R_KV  = 4'd6;
  localparam logic [3:0] ST_R_SUM = 4'd7;
  localparam logic [3:0] ST_R_OUT = 4'd8;
  localparam logic [3:0] ST_P_KI  = 4'd9;
  localparam logic [3:0] ST_P_KV  = 4'd10;
  localparam logic [3:0] ST_P_SUB = 4'd11;
  localparam logic [3:0] ST_P_W1  = 4'd12;
  localparam logic [3:0] ST_P_DIV = 4'd13;
  localparam logic [3:0] ST_P_W2  = 4'd14;

  logic [3:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    ovalid_d = ovalid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (in_op_i)
            OP_RUN:     state_d = ST_R_INC;
            OP_PRELOAD: state_d = ST_P_KI;
            OP_CLEAR:   cmd_o.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_R_INC: begin cmd_o.mul_sel = MUL_INC; state_d = ST_R_INT; end
      ST_R_INT: begin cmd_o.integ_upd = 1'b1; state_d = ST_R_HI; end
      ST_R_HI:  begin cmd_o.mul_sel = MUL_HI; state_d = ST_R_LO; end
      ST_R_LO: begin
        cmd_o.acc_op = ACC_LOAD; cmd_o.mul_sel = MUL_LO; state_d = ST_R_KI;
      end
      ST_R_KI: begin
        cmd_o.acc_op = ACC_ITERM; cmd_o.mul_sel = MUL_KI; state_d = ST_R_KV;
      end
      ST_R_KV: begin
        cmd_o.acc_op = ACC_ADD; cmd_o.mul_sel = MUL_KV_V; state_d = ST_R_SUM;
      end
      ST_R_SUM: begin cmd_o.acc_op = ACC_ADD; state_d = ST_R_OUT; end
      ST_R_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_P_KI: begin
        cmd_o.div_start = 1'b1; cmd_o.mul_sel = MUL_KI; state_d = ST_P_KV;
      end
      ST_P_KV: begin
        cmd_o.acc_op = ACC_NEG; cmd_o.mul_sel = MUL_KV_VDC; state_d = ST_P_SUB;
      end
      ST_P_SUB: begin cmd_o.acc_op = ACC_SUB; state_d = ST_P_W1; end
      ST_P_W1: begin
        if (!sts_i.div_busy) begin
          cmd_o.acc_op = ACC_RATIO; state_d = ST_P_DIV;
        end
      end
      ST_P_DIV: begin
        cmd_o.div_start = 1'b1; cmd_o.div_sel = 1'b1; state_d = ST_P_W2;
      end
      ST_P_W2: begin
        cmd_o.div_sel = 1'b1;
        if (!sts_i.div_busy) begin
          cmd_o.preload_fin = 1'b1; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
endmodule
`default_nettype wire
